/* design/lwm_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// LZSS window longest-match finder. No dependencies.
package lwm_pkg;

    localparam int WINDOW_DEPTH = 1024;
    localparam int MAX_MATCH    = 16;
    localparam int PAT_DEPTH    = 16;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int PAT_AW       = $clog2(PAT_DEPTH);
    localparam int IDX_W        = 10;
    localparam int LEN_W        = 5;
    localparam int OP_W         = 2;

    localparam logic [OP_W-1:0] OP_WR_WIN  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_PAT  = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;   // no action, no output word

    // controller -> datapath commands
    typedef struct packed {
        logic clr;   // start search: clear best, position, latch limit
        logic adv;   // byte matched, move to next byte of candidate
        logic fin;   // close candidate, update best, next position
        logic inc;   // on fin: current byte matched as well
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic short_len;  // pattern too short for any match
        logic eq;         // window byte equals pattern byte
        logic last_byte;  // no further byte may be compared
        logic fin_done;   // closing this candidate ends the scan
    } t_status;

endpackage

/* design/lwm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lwm_datapath.sv */
// Datapath: window RAM, pattern registers, scan position and best-match
// registers. Depends on lwm_pkg and lwm_ram.
module lwm_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_win,
    input  logic                       i_wr_pat,
    input  logic [lwm_pkg::IDX_W-1:0]  i_wr_addr,
    input  logic [7:0]                 i_wr_byte,
    input  logic [lwm_pkg::LEN_W-1:0]  i_plen,
    input  logic [1:0]                 i_min_len,
    input  lwm_pkg::t_cmd              i_cmd,
    output lwm_pkg::t_status           o_status,
    output logic [lwm_pkg::IDX_W-1:0]  o_best_pos,
    output logic [lwm_pkg::LEN_W-1:0]  o_best_len
);

    logic [7:0]                       r_pat [lwm_pkg::PAT_DEPTH];
    logic [lwm_pkg::WIN_AW-1:0]       r_pos;
    logic [lwm_pkg::PAT_AW-1:0]       r_i;
    logic [lwm_pkg::LEN_W-1:0]        r_limit;
    logic [lwm_pkg::WIN_AW-1:0]       r_best_pos;
    logic [lwm_pkg::LEN_W-1:0]        r_best_len;

    logic [lwm_pkg::WIN_AW:0]         rd_sum;
    logic [lwm_pkg::WIN_AW-1:0]       rd_addr;
    logic [7:0]                       rdata;
    logic [lwm_pkg::LEN_W-1:0]        i_next;
    logic [lwm_pkg::LEN_W-1:0]        len_c;
    logic [lwm_pkg::LEN_W-1:0]        n_limit;
    logic [2:0]                       min_eff;
    logic                             better;
    logic                             win_we;

    // window byte store
    assign win_we = i_wr_win
        && ({1'b0, i_wr_addr} < (lwm_pkg::IDX_W+1)'(lwm_pkg::WINDOW_DEPTH));
    assign rd_sum  = {1'b0, r_pos} + (lwm_pkg::WIN_AW+1)'(r_i);
    assign rd_addr = rd_sum[lwm_pkg::WIN_AW-1:0];

    lwm_ram #(.WIDTH(8), .DEPTH(lwm_pkg::WINDOW_DEPTH)) u_win (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (lwm_pkg::WIN_AW'(i_wr_addr)),
        .i_wdata (i_wr_byte),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // minimum below two acts as two; limit is length clamped to max match
    assign min_eff = (i_min_len < 2'd2) ? 3'd2 : {1'b0, i_min_len};
    assign n_limit = (i_plen > lwm_pkg::LEN_W'(lwm_pkg::MAX_MATCH))
                   ? lwm_pkg::LEN_W'(lwm_pkg::MAX_MATCH) : i_plen;

    assign i_next = lwm_pkg::LEN_W'(r_i) + 1'b1;
    assign len_c  = o_status.eq ? i_next : lwm_pkg::LEN_W'(r_i);
    assign better = (len_c >= 5'd2) && (len_c > r_best_len);

    always_comb begin
        o_status.short_len = (i_plen < lwm_pkg::LEN_W'(min_eff));
        o_status.eq        = (rdata == r_pat[r_i]);
        o_status.last_byte = (i_next == r_limit)
            || (rd_sum == (lwm_pkg::WIN_AW+1)'(lwm_pkg::WINDOW_DEPTH - 1));
        o_status.fin_done  = (better && (len_c == r_limit))
            || (r_pos == lwm_pkg::WIN_AW'(lwm_pkg::WINDOW_DEPTH - 2));
    end

    // pattern store
    always_ff @(posedge i_clk) begin
        if (i_wr_pat && (i_wr_addr < lwm_pkg::IDX_W'(lwm_pkg::PAT_DEPTH))) begin
            r_pat[i_wr_addr[lwm_pkg::PAT_AW-1:0]] <= i_wr_byte;
        end
    end

    // scan counters and best match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_i        <= '0;
            r_limit    <= '0;
            r_best_pos <= '0;
            r_best_len <= '0;
        end else if (i_cmd.clr) begin
            r_pos      <= '0;
            r_i        <= '0;
            r_limit    <= n_limit;
            r_best_pos <= '0;
            r_best_len <= '0;
        end else if (i_cmd.adv) begin
            r_i <= r_i + 1'b1;
        end else if (i_cmd.fin) begin
            if (better) begin
                r_best_len <= len_c;
                r_best_pos <= r_pos;
            end
            if (!o_status.fin_done) begin
                r_pos <= r_pos + 1'b1;
            end
            r_i <= '0;
        end
    end

    assign o_best_pos = lwm_pkg::IDX_W'(r_best_pos);
    assign o_best_len = r_best_len;

endmodule

/* design/lwm_ctrl.sv */
// Controller: sequences the search scan and the hand-off to the output word.
// Depends on lwm_pkg.
module lwm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,      // search word accepted
    input  lwm_pkg::t_status i_status,
    input  logic             i_out_free,   // output register may be loaded
    output lwm_pkg::t_cmd    o_cmd,
    output logic             o_idle,
    output logic             o_load
);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_CMP, S_OUT} t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.clr = 1'b1;
                    n_state   = i_status.short_len ? S_OUT : S_RD;
                end
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (i_status.eq && !i_status.last_byte) begin
                    o_cmd.adv = 1'b1;
                    n_state   = S_RD;
                end else begin
                    o_cmd.fin = 1'b1;
                    o_cmd.inc = i_status.eq;
                    n_state   = i_status.fin_done ? S_OUT : S_RD;
                end
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

/* design/lz_window_longest_match.sv */
// Top level of the LZSS window longest-match finder.
// Depends on lwm_pkg, lwm_ctrl and lwm_datapath.
//
// Input words (s_axis): tuser selects the kind: window byte write, pattern
// byte write or search. Writes give no output word and leave s_axis_tready
// high. A search gives exactly one output word (m_axis) with the best match
// position and length (length 0: no match).
// A search steps through a read state and a compare state for each window
// byte compared: the window RAM has a single read port and a registered
// read. A pattern that is too short goes straight to the output state.
// i_cfg_we writes the minimum length register; the user must do so only at
// an idle time, as the block itself does not enforce this.
// One search is worked on at a time; s_axis_tready is low while it runs.
// The result sits in an output register: the block takes new words while it
// waits, and a further search only stalls at its end if the register is
// still full. A stalled receiver holds m_axis_tdata steady.
// Reset (synchronous, active low) clears control state and sets the minimum
// length to two; window and pattern contents are undefined until written.
module lz_window_longest_match (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,    // min_match_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // address[9:0], byte_value[17:10],
                                        // pattern_length[22:18], zero pad
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // match_pos[9:0],
                                        // match_length[14:10], zero pad
);

    logic [1:0]                      r_min_len;
    logic                            r_out_valid;
    logic [lwm_pkg::IDX_W-1:0]       r_out_idx;
    logic [lwm_pkg::LEN_W-1:0]       r_out_len;

    logic                            accept;
    logic                            idle;
    logic                            load;
    logic                            out_free;
    lwm_pkg::t_cmd                   cmd;
    lwm_pkg::t_status                status;
    logic [lwm_pkg::IDX_W-1:0]       best_pos;
    logic [lwm_pkg::LEN_W-1:0]       best_len;

    assign s_axis_tready = idle;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    // minimum length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= 2'd2;
        end else if (i_cfg_we) begin
            r_min_len <= i_cfg_wdata;
        end
    end

    lwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept && (s_axis_tuser == lwm_pkg::OP_SEARCH)),
        .i_status   (status),
        .i_out_free (out_free),
        .o_cmd      (cmd),
        .o_idle     (idle),
        .o_load     (load)
    );

    lwm_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_win   (accept && (s_axis_tuser == lwm_pkg::OP_WR_WIN)),
        .i_wr_pat   (accept && (s_axis_tuser == lwm_pkg::OP_WR_PAT)),
        .i_wr_addr  (s_axis_tdata[9:0]),
        .i_wr_byte  (s_axis_tdata[17:10]),
        .i_plen     (s_axis_tdata[22:18]),
        .i_min_len  (r_min_len),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_best_pos (best_pos),
        .o_best_len (best_len)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_idx <= best_pos;
            r_out_len <= best_len;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_len, r_out_idx};

    // a search blocks further input on the following cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (s_axis_tuser == lwm_pkg::OP_SEARCH)) |=> !s_axis_tready)
        else $error("input taken while search runs");

    // reported length never exceeds the clamp and is never one
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_len <= lwm_pkg::LEN_W'(lwm_pkg::MAX_MATCH))
                         && (r_out_len != 5'd1)))
        else $error("match length out of range");

    // no length means position zero
    a_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_len == '0)) |-> (r_out_idx == '0))
        else $error("position set without a match");

    // result register is only loaded when free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> out_free)
        else $error("output word overwritten");

endmodule

/* tb/tb_top.sv */
// Self-checking bench for lz_window_longest_match: stream words in, search results out.
// Depends on lwm_pkg and the RTL; a built-in match predictor supplies the expected words.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [lwm_pkg::OP_W-1:0]  op;
        logic [lwm_pkg::IDX_W-1:0] addr;
        logic [7:0]                value;
        logic [lwm_pkg::LEN_W-1:0] plen;
    } t_word;

    typedef struct packed {
        logic [lwm_pkg::IDX_W-1:0] index;
        logic [lwm_pkg::LEN_W-1:0] length;
    } t_match;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = 2'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    lz_window_longest_match dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state, updated as words are accepted
    logic [7:0] window_bytes [lwm_pkg::WINDOW_DEPTH];
    logic [7:0] pattern_bytes [lwm_pkg::PAT_DEPTH];
    int unsigned min_len_reg = 2;
    // shadow of the window as the stimulus is generated (same order)
    logic [7:0] gen_window [lwm_pkg::WINDOW_DEPTH];

    t_word  pending_words[$];
    t_match expected_matches[$];
    int     failures = 0;
    int     accepted_cnt = 0;
    int     issued_cnt = 0;
    int     src_idle = 15;
    int     snk_idle = 86;
    int     hold_req = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    t_word  cur_word;

    function automatic t_match find_longest(int unsigned plen);
        t_match      best;
        int unsigned lim, min_eff, len;
        best = '0;
        min_eff = (min_len_reg < 2) ? 2 : min_len_reg;
        if (plen >= min_eff) begin
            lim = (plen < lwm_pkg::MAX_MATCH) ? plen : lwm_pkg::MAX_MATCH;
            for (int p = 0; p + 1 < lwm_pkg::WINDOW_DEPTH; p++) begin
                if (window_bytes[lwm_pkg::WIN_AW'(p)] != pattern_bytes[0] ||
                    window_bytes[lwm_pkg::WIN_AW'(p + 1)] != pattern_bytes[1])
                    continue;
                len = 2;
                for (int i = 2; i < lim; i++) begin
                    if (p + i > lwm_pkg::WINDOW_DEPTH - 1) break;
                    if (window_bytes[lwm_pkg::WIN_AW'(p + i)] !=
                        pattern_bytes[lwm_pkg::PAT_AW'(i)]) break;
                    len = i + 1;
                end
                if (len > best.length) begin
                    best.length = lwm_pkg::LEN_W'(len);
                    best.index  = lwm_pkg::IDX_W'(p);
                    if (len == lim) break;
                end
            end
        end
        return best;
    endfunction

    // input side: acceptance updates the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            accepted_cnt <= accepted_cnt + 1;
            case (cur_word.op)
                lwm_pkg::OP_WR_WIN: window_bytes[cur_word.addr] = cur_word.value;
                lwm_pkg::OP_WR_PAT: if (cur_word.addr < lwm_pkg::PAT_DEPTH)
                    pattern_bytes[cur_word.addr[lwm_pkg::PAT_AW-1:0]] = cur_word.value;
                lwm_pkg::OP_SEARCH:
                    expected_matches.push_back(find_longest(cur_word.plen));
                default: ;
            endcase
        end
    end

    // driver: next word offered at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || accepted_cnt == issued_cnt)) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= src_idle) begin
                cur_word      <= pending_words[0];
                s_axis_tdata  <= {1'b0, pending_words[0].plen, pending_words[0].value,
                                  pending_words[0].addr};
                s_axis_tuser  <= pending_words[0].op;
                s_axis_tvalid <= 1'b1;
                issued_cnt    <= issued_cnt + 1;
                void'(pending_words.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver readiness, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= 6000;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(99) >= snk_idle);
        end
    end

    // output side: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        t_match got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.index  = m_axis_tdata[9:0];
            got.length = m_axis_tdata[14:10];
            if (expected_matches.size() == 0) begin
                $display("%0t: unexpected result word idx=%0d len=%0d",
                         $time, got.index, got.length);
                failures++;
            end else begin
                if (got.length != expected_matches[0].length) begin
                    $display("%0t: match_length expected %0d actual %0d",
                             $time, expected_matches[0].length, got.length);
                    failures++;
                end
                if (got.index != expected_matches[0].index) begin
                    $display("%0t: match position expected %0d actual %0d",
                             $time, expected_matches[0].index, got.index);
                    failures++;
                end
                void'(expected_matches.pop_front());
            end
        end
    end

    task automatic push_word(logic [1:0] op, int addr, int value, int plen);
        t_word w;
        w.op    = op;
        w.addr  = lwm_pkg::IDX_W'(addr);
        w.value = 8'(value);
        w.plen  = lwm_pkg::LEN_W'(plen);
        if (op == lwm_pkg::OP_WR_WIN) gen_window[lwm_pkg::WIN_AW'(addr)] = 8'(value);
        pending_words.push_back(w);
    endtask

    // sender pauses until every result is in, then lets the block settle
    task automatic wait_idle();
        while (pending_words.size() > 0 || accepted_cnt != issued_cnt ||
               expected_matches.size() > 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_min(int v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 2'(v);
        min_len_reg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly random noise words, plus pattern copies from the window followed by a search
    task automatic random_phase(int n);
        int pos, r, len;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 12) begin
                pos = $urandom_range(lwm_pkg::WINDOW_DEPTH - 2);
                len = $urandom_range(2, 16);
                for (int i = 0; i < len; i++)
                    push_word(lwm_pkg::OP_WR_PAT, i, (pos + i < lwm_pkg::WINDOW_DEPTH) ?
                              gen_window[lwm_pkg::WIN_AW'(pos + i)] : $urandom_range(255),
                              0);
                push_word(lwm_pkg::OP_SEARCH, $urandom_range(1023), $urandom_range(255),
                          ($urandom_range(9) == 0) ? $urandom_range(31) : len);
            end else if (r < 60) begin
                push_word(lwm_pkg::OP_WR_WIN, $urandom_range(1023),
                          ($urandom_range(3) == 0) ? $urandom_range(255)
                                                   : $urandom_range(3), 0);
            end else if (r < 75) begin
                push_word(lwm_pkg::OP_WR_PAT,
                          ($urandom_range(7) == 0) ? $urandom_range(1023)
                                                   : $urandom_range(15),
                          ($urandom_range(1) == 0) ? $urandom_range(255)
                                                   : $urandom_range(3), 0);
            end else if (r < 92) begin
                push_word(lwm_pkg::OP_SEARCH, $urandom_range(1023), $urandom_range(255),
                          $urandom_range(31));
            end else begin
                push_word(lwm_pkg::OP_UNUSED, $urandom_range(1023), $urandom_range(255),
                          $urandom_range(31));
            end
        end
    endtask

    initial begin
        // watchdog
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill every window and pattern entry before any search
        for (int a = 0; a < lwm_pkg::WINDOW_DEPTH - 16; a++)
            push_word(lwm_pkg::OP_WR_WIN, a, $urandom_range(3), 0);
        for (int i = 0; i < lwm_pkg::PAT_DEPTH; i++) begin
            push_word(lwm_pkg::OP_WR_PAT, i, $urandom_range(3), 0);
            push_word(lwm_pkg::OP_WR_WIN, lwm_pkg::WINDOW_DEPTH - 16 + i, 0, 0);
        end
        // byte extremes, then a full-length copy of the pattern at the window tail
        push_word(lwm_pkg::OP_WR_WIN, 5, 8'hFF, 0);
        push_word(lwm_pkg::OP_WR_WIN, 6, 8'h00, 0);
        push_word(lwm_pkg::OP_WR_PAT, 15, 8'hAA, 0);
        push_word(lwm_pkg::OP_WR_PAT, 15, 8'h55, 0);
        push_word(lwm_pkg::OP_WR_PAT, 1023, 8'hFF, 0);   // out of range, ignored
        push_word(lwm_pkg::OP_WR_PAT, 16, 8'h00, 0);     // out of range, ignored
        wait_idle();
        for (int i = 0; i < lwm_pkg::PAT_DEPTH; i++)
            push_word(lwm_pkg::OP_WR_WIN, lwm_pkg::WINDOW_DEPTH - 16 + i,
                      pattern_bytes[lwm_pkg::PAT_AW'(i)], 0);
        push_word(lwm_pkg::OP_SEARCH, 0, 0, 0);
        push_word(lwm_pkg::OP_SEARCH, 1023, 255, 1);
        push_word(lwm_pkg::OP_SEARCH, 0, 0, 2);
        push_word(lwm_pkg::OP_SEARCH, 0, 0, 3);
        push_word(lwm_pkg::OP_SEARCH, 0, 0, 16);
        push_word(lwm_pkg::OP_SEARCH, 0, 0, 17);
        push_word(lwm_pkg::OP_SEARCH, 1023, 255, 31);
        push_word(lwm_pkg::OP_UNUSED, 1023, 255, 31);
        // pattern seed on the last two window bytes: no wrap past the end
        push_word(lwm_pkg::OP_WR_PAT, 0, pattern_bytes[14], 0);
        push_word(lwm_pkg::OP_WR_PAT, 1, pattern_bytes[15], 0);
        push_word(lwm_pkg::OP_SEARCH, 0, 0, 16);
        wait_idle();

        write_min(3);
        push_word(lwm_pkg::OP_SEARCH, 0, 0, 2);
        push_word(lwm_pkg::OP_SEARCH, 0, 0, 3);
        random_phase(40);
        wait_idle();

        src_idle = 86; snk_idle = 15;
        write_min(0);
        push_word(lwm_pkg::OP_SEARCH, 0, 0, 2);
        random_phase(40);
        wait_idle();

        src_idle = 0; snk_idle = 0;
        write_min(1);
        random_phase(25);
        wait_idle();

        // long receiver hold-off while searches keep coming
        write_min(2);
        hold_req = 1;
        for (int k = 0; k < 4; k++) begin
            push_word(lwm_pkg::OP_SEARCH, 0, 0, $urandom_range(2, 16));
            push_word(lwm_pkg::OP_WR_WIN, $urandom_range(1023), $urandom_range(3), 0);
        end
        random_phase(15);
        wait_idle();

        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
design/lwm_pkg.sv
design/lwm_ram.sv
design/lwm_datapath.sv
design/lwm_ctrl.sv
design/lz_window_longest_match.sv
tb/tb_top.sv
